[hdl/nfa_pkg.sv]
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared widths, codes and controller/datapath structs of the next-fit
// run slot allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfa_pkg;

	// item field widths
	localparam int ACTION_W = 1;
	localparam int BASE_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int SLOT_W   = 10;
	localparam int STATUS_W = 3;

	// configuration port
	localparam int SIZE_W  = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0]        REG_ACTIVE_SIZE = 1'b0;
	localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 11'd1024;

	// bitmap word organization
	localparam int WORD_W = 16;
	localparam int WBIT_W = 4;

	// actions
	localparam logic [ACTION_W-1:0] ACT_ALLOC   = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_COUNT    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREED_FREE   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd4;

	typedef struct packed {
		logic clear;
		logic load_req;
		logic check;
		logic scan;
		logic mark;
		logic unmark;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic early;
		logic is_release;
		logic scan_found;
		logic scan_fail;
		logic mark_done;
		logic unmark_done;
	} dp_stat_t;

endpackage

[hdl/nfa_req_if.sv]
// ----------------------------------------------------------------------------
// nfa_req_if
// Request channel: valid/ready handshake with the allocate or release item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nfa_req_if;
	import nfa_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [BASE_W-1:0]   run_base;
	logic [COUNT_W-1:0]  count;

	modport source (output valid, action, run_base, count, input ready);
	modport sink   (input valid, action, run_base, count, output ready);

endinterface

[hdl/nfa_rsp_if.sv]
// ----------------------------------------------------------------------------
// nfa_rsp_if
// Response channel: valid/ready handshake with the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nfa_rsp_if;
	import nfa_pkg::*;

	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   slot_index;
	logic [STATUS_W-1:0] status;

	modport source (output valid, slot_index, status, input ready);
	modport sink   (input valid, slot_index, status, output ready);

endinterface

[hdl/nfa_ram.sv]
// ----------------------------------------------------------------------------
// nfa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/nfa_dp.sv]
// ----------------------------------------------------------------------------
// nfa_dp
// Datapath: bitmap RAM, search pointer, word-wise run scan, mark and
// release read-modify-write, result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfa_dp #(
	parameter int CAPACITY = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nfa_pkg::ctl_cmd_t             cmd,
	output nfa_pkg::dp_stat_t             stat,
	input  logic [nfa_pkg::SIZE_W-1:0]    active_size,
	input  logic [nfa_pkg::ACTION_W-1:0]  in_action,
	input  logic [nfa_pkg::BASE_W-1:0]    in_run_base,
	input  logic [nfa_pkg::COUNT_W-1:0]   in_count,
	output logic [nfa_pkg::SLOT_W-1:0]    out_slot_index,
	output logic [nfa_pkg::STATUS_W-1:0]  out_status
);
	import nfa_pkg::*;

	localparam int SZ_W  = $clog2(CAPACITY + 1);
	localparam int AW    = ((SZ_W > COUNT_W) ? SZ_W : COUNT_W) + 1;
	localparam int PTR_W = $clog2(CAPACITY);
	localparam int NW    = (CAPACITY + WORD_W - 1) / WORD_W;
	localparam int WA_W  = (NW > 1) ? $clog2(NW) : 1;

	// request registers
	logic [ACTION_W-1:0] act_q;
	logic [AW-1:0]       base_q;
	logic [AW-1:0]       cnt_q;
	logic [AW-1:0]       size_q;
	logic [PTR_W-1:0]    ptr_q;

	// word window of the current pass
	logic [WA_W-1:0]   firstw_q, lastw_q, rd_word_q, clr_q;
	logic [WBIT_W-1:0] lo_q, hi_q;
	logic              issued_all_q;
	logic [AW-1:0]     run_q;

	// read return stage
	logic            pend_s1;
	logic [WA_W-1:0] addr_s1;

	logic [SLOT_W-1:0]   res_slot_q, rsp_slot_q;
	logic [STATUS_W-1:0] res_status_q, rsp_status_q;

	// ram ports
	logic              ram_we, rd_en;
	logic [WA_W-1:0]   ram_waddr;
	logic [WORD_W-1:0] ram_wdata, rdata;

	// effective size
	logic [AW-1:0] act_ext, eff_size;
	always_comb begin
		act_ext = AW'(active_size);
		if (act_ext == '0) begin
			eff_size = AW'(1);
		end else if (act_ext > AW'(CAPACITY)) begin
			eff_size = AW'(CAPACITY);
		end else begin
			eff_size = act_ext;
		end
	end

	// check of the latched request
	logic [AW-1:0]       ptr_ext, end_rel, start_idx, end_idx;
	logic                is_rel, cnt_zero, early;
	logic [STATUS_W-1:0] early_status;
	always_comb begin
		ptr_ext   = AW'(ptr_q);
		is_rel    = (act_q == ACT_RELEASE);
		cnt_zero  = (cnt_q == '0);
		end_rel   = base_q + cnt_q;
		early     = cnt_zero || (is_rel ? (end_rel > size_q) : (ptr_ext >= size_q));
		if (cnt_zero) begin
			early_status = is_rel ? ST_OK : ST_BAD_COUNT;
		end else begin
			early_status = is_rel ? ST_OUT_OF_RANGE : ST_NO_SPACE;
		end
		start_idx = is_rel ? base_q : ptr_ext;
		end_idx   = is_rel ? (end_rel - AW'(1)) : (size_q - AW'(1));
	end

	// in-window mask of the returned word
	logic [WORD_W-1:0] mask;
	logic              is_last;
	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			mask[j] = ((addr_s1 != firstw_q) || (WBIT_W'(j) >= lo_q)) &&
				((addr_s1 != lastw_q) || (WBIT_W'(j) <= hi_q));
		end
		is_last = (addr_s1 == lastw_q);
	end

	// run scan: free run length ending at each bit, carried in from run_q
	logic [WORD_W-1:0] used, hit;
	logic [AW-1:0]     run_v [WORD_W];
	logic [WBIT_W-1:0] jsel;
	logic              any_hit;
	always_comb begin
		logic              lu_found;
		logic [WBIT_W-1:0] lu_pos;
		logic [WBIT_W:0]   zlen;
		used = rdata | ~mask;
		for (int j = 0; j < WORD_W; j++) begin
			lu_found = 1'b0;
			lu_pos   = '0;
			for (int k = 0; k <= j; k++) begin
				if (used[k]) begin
					lu_found = 1'b1;
					lu_pos   = WBIT_W'(k);
				end
			end
			zlen     = (WBIT_W + 1)'(j) - {1'b0, lu_pos};
			run_v[j] = lu_found ? AW'(zlen) : (run_q + AW'(j + 1));
			hit[j]   = (run_v[j] >= cnt_q);
		end
		any_hit = |hit;
		jsel    = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (hit[j]) begin
				jsel = WBIT_W'(j);
			end
		end
	end

	logic [AW-1:0] pos_idx, fb_idx, nxt_idx;
	always_comb begin
		pos_idx                  = '0;
		pos_idx[WBIT_W +: WA_W]  = addr_s1;
		pos_idx[WBIT_W-1:0]      = jsel;
		fb_idx                   = pos_idx + AW'(1) - cnt_q;
		nxt_idx                  = pos_idx + AW'(1);
	end

	// release: first free slot inside the window stops the pass
	logic [WORD_W-1:0] bad, keep;
	logic [WBIT_W-1:0] jbad;
	logic              any_bad;
	always_comb begin
		bad     = mask & ~rdata;
		any_bad = |bad;
		jbad    = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (bad[j]) begin
				jbad = WBIT_W'(j);
			end
		end
		for (int j = 0; j < WORD_W; j++) begin
			keep[j] = mask[j] && (WBIT_W'(j) < jbad);
		end
	end

	logic scan_found, scan_fail, mark_done, unmark_done, term;
	assign scan_found  = pend_s1 && cmd.scan && any_hit;
	assign scan_fail   = pend_s1 && cmd.scan && !any_hit && is_last;
	assign mark_done   = pend_s1 && cmd.mark && is_last;
	assign unmark_done = pend_s1 && cmd.unmark && (any_bad || is_last);
	assign term        = scan_found || scan_fail || mark_done || unmark_done;

	assign rd_en = (cmd.scan || cmd.mark || cmd.unmark) && !issued_all_q && !term;

	always_comb begin
		ram_we    = cmd.clear || (pend_s1 && (cmd.mark || cmd.unmark));
		ram_waddr = cmd.clear ? clr_q : addr_s1;
		if (cmd.clear) begin
			ram_wdata = '0;
		end else if (cmd.mark) begin
			ram_wdata = rdata | mask;
		end else begin
			ram_wdata = rdata & ~(any_bad ? keep : mask);
		end
	end

	nfa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NW),
		.ADDR_W(WA_W)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(rd_word_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			clr_q        <= '0;
			pend_s1      <= 1'b0;
			issued_all_q <= 1'b1;
			firstw_q     <= '0;
			lastw_q      <= '0;
			rd_word_q    <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			run_q        <= '0;
			res_slot_q   <= '0;
			res_status_q <= ST_OK;
		end else begin
			pend_s1 <= rd_en;
			if (cmd.clear) begin
				clr_q <= clr_q + WA_W'(1);
			end
			if (rd_en) begin
				rd_word_q <= rd_word_q + WA_W'(1);
				if (rd_word_q == lastw_q) begin
					issued_all_q <= 1'b1;
				end
			end
			if (cmd.load_req) begin
				res_slot_q   <= '0;
				res_status_q <= ST_OK;
			end
			if (cmd.check) begin
				firstw_q     <= start_idx[WBIT_W +: WA_W];
				lo_q         <= start_idx[WBIT_W-1:0];
				lastw_q      <= end_idx[WBIT_W +: WA_W];
				hi_q         <= end_idx[WBIT_W-1:0];
				rd_word_q    <= start_idx[WBIT_W +: WA_W];
				issued_all_q <= 1'b0;
				run_q        <= '0;
				if (early) begin
					res_status_q <= early_status;
				end
			end
			if (pend_s1 && cmd.scan) begin
				run_q <= run_v[WORD_W-1];
			end
			if (scan_found) begin
				res_slot_q   <= fb_idx[SLOT_W-1:0];
				ptr_q        <= (nxt_idx == size_q) ? '0 : nxt_idx[PTR_W-1:0];
				firstw_q     <= fb_idx[WBIT_W +: WA_W];
				lo_q         <= fb_idx[WBIT_W-1:0];
				lastw_q      <= addr_s1;
				hi_q         <= jsel;
				rd_word_q    <= fb_idx[WBIT_W +: WA_W];
				issued_all_q <= 1'b0;
			end
			if (scan_fail) begin
				res_status_q <= ST_NO_SPACE;
			end
			if (unmark_done) begin
				if (any_bad) begin
					res_status_q <= ST_FREED_FREE;
				end else if (ptr_ext > base_q) begin
					ptr_q <= base_q[PTR_W-1:0];
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= rd_word_q;
		if (cmd.load_req) begin
			act_q  <= in_action;
			base_q <= AW'(in_run_base);
			cnt_q  <= AW'(in_count);
			size_q <= eff_size;
		end
		if (cmd.out_load) begin
			rsp_slot_q   <= res_slot_q;
			rsp_status_q <= res_status_q;
		end
	end

	always_comb begin
		stat.clear_last  = (clr_q == WA_W'(NW - 1));
		stat.early       = early;
		stat.is_release  = is_rel;
		stat.scan_found  = scan_found;
		stat.scan_fail   = scan_fail;
		stat.mark_done   = mark_done;
		stat.unmark_done = unmark_done;
	end

	assign out_slot_index = rsp_slot_q;
	assign out_status     = rsp_status_q;

	a_rmw_window: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && (cmd.mark || cmd.unmark) |-> addr_s1 >= firstw_q && addr_s1 <= lastw_q)
		else $error("bitmap write outside the run window");

	a_found_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		scan_found |-> fb_idx >= ptr_ext && pos_idx < size_q)
		else $error("found run outside the searched range");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !rd_en && !pend_s1)
		else $error("bitmap read during clearing pass");

endmodule

[hdl/nfa_ctrl.sv]
// ----------------------------------------------------------------------------
// nfa_ctrl
// Controller: clearing pass after reset, request sequencing through check,
// scan, mark or release, and the output valid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  nfa_pkg::dp_stat_t stat,
	output nfa_pkg::ctl_cmd_t cmd
);
	import nfa_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_MARK   = 3'd4;
	localparam logic [2:0] S_UNMARK = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.early) begin
					state_d = S_DONE;
				end else if (stat.is_release) begin
					state_d = S_UNMARK;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_found) begin
					state_d = S_MARK;
				end else if (stat.scan_fail) begin
					state_d = S_DONE;
				end
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				if (stat.mark_done) begin
					state_d = S_DONE;
				end
			end
			S_UNMARK: begin
				cmd.unmark = 1'b1;
				if (stat.unmark_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_CHECK)
		else $error("accepted item not checked next cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

endmodule

[hdl/next_fit_run_slot_allocator_unit.sv]
// ----------------------------------------------------------------------------
// next_fit_run_slot_allocator_unit
// Allocate goes through check, scan and mark; release through check and
// unmark; zero counts and early failures go from check to the result
// (16 slots a word, one bitmap RAM word read per cycle).
// One item at a time: the next item is taken once the result is registered.
// Reset clears control state, not the payload registers; a clearing pass then
// zeroes the CAPACITY/16 bitmap words (64 by default) with req.ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module next_fit_run_slot_allocator_unit #(
	parameter int CAPACITY = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nfa_pkg::PADDR_W-1:0]  paddr,
	input  logic [nfa_pkg::PDATA_W-1:0]  pwdata,
	output logic [nfa_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	nfa_req_if.sink                      req,
	nfa_rsp_if.source                    rsp
);
	import nfa_pkg::*;

	logic [SIZE_W-1:0] active_q;
	logic              cfg_wr;
	ctl_cmd_t          cmd;
	dp_stat_t          stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_SIZE_RST;
		end else if (cfg_wr && (paddr[PADDR_W-1] == REG_ACTIVE_SIZE)) begin
			active_q <= pwdata[SIZE_W-1:0];
		end
	end

	assign prdata = (paddr[PADDR_W-1] == REG_ACTIVE_SIZE) ? PDATA_W'(active_q) : '0;

	nfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	nfa_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.active_size   (active_q),
		.in_action     (req.action),
		.in_run_base   (req.run_base),
		.in_count      (req.count),
		.out_slot_index(rsp.slot_index),
		.out_status    (rsp.status)
	);

endmodule
